// ===== sv/mtsd_pkg.sv =====
// ---------------------------------------------------------------------------
// mtsd_pkg
// shared widths, reset values, controller states and the command and status
// structs that pass between the controller and the datapath
// ---------------------------------------------------------------------------
package mtsd_pkg;

    localparam int SAMPLE_W = 24;
    localparam int OUT_W    = 28;
    localparam int SPC_W    = 10;

    localparam logic [SPC_W-1:0] SPACING_RESET = 10'd256;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_TAP   = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic tap;
        logic acc;
        logic clr_wr;
        logic frm_wr;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic pos_last;
    } t_sts;

endpackage

// ===== sv/multi_tap_stereo_delay_mix_core.sv =====
// ---------------------------------------------------------------------------
// multi_tap_stereo_delay_mix_core
// stereo multi-tap delay mixer: dry sample plus VOICES taps per channel,
// spaced tap_spacing frames apart (clamped to 1..MAX_GAP), from a shared history ram
// ---------------------------------------------------------------------------
// Each frame request runs through IDLE (take the frame), TAP (one tap a
// cycle on the single read port of the history ram), WRITE (the history
// write) and DONE (load the output register, once it is free or its result
// is taken). A finished result waits in the output register while the
// next frame is taken. After reset the history is cleared one entry a cycle,
// all VOICES * MAX_GAP entries (2048 at the defaults), during which o_in_stall is
// high; spacing writes are taken at any time and only ever from i_cfg_data.
module multi_tap_stereo_delay_mix_core #(
    parameter int VOICES  = 4,
    parameter int MAX_GAP = 512
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [mtsd_pkg::SAMPLE_W-1:0] i_left_in,
    input  logic signed [mtsd_pkg::SAMPLE_W-1:0] i_right_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [mtsd_pkg::OUT_W-1:0]    o_left_out,
    output logic signed [mtsd_pkg::OUT_W-1:0]    o_right_out,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mtsd_pkg::SPC_W-1:0]           i_cfg_data
);

    mtsd_pkg::t_cmd cmd;
    mtsd_pkg::t_sts sts;

    mtsd_ctrl #(
        .VOICES (VOICES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mtsd_dp #(
        .VOICES  (VOICES),
        .MAX_GAP (MAX_GAP)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_left_in   (i_left_in),
        .i_right_in  (i_right_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out)
    );

    assign o_cfg_ready = 1'b1;

endmodule

// ===== sv/mtsd_ram.sv =====
// ---------------------------------------------------------------------------
// mtsd_ram
// generic single write port, single read port memory with registered read
// ---------------------------------------------------------------------------
module mtsd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/mtsd_ctrl.sv =====
// ---------------------------------------------------------------------------
// mtsd_ctrl
// sequencer: history clear, frame request intake, one tap read per cycle,
// history write and result hand-off to the output register
// ---------------------------------------------------------------------------
module mtsd_ctrl #(
    parameter int VOICES = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  mtsd_pkg::t_sts i_sts,
    output mtsd_pkg::t_cmd o_cmd
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

    mtsd_pkg::t_state r_state, n_state;
    logic [VW-1:0]    r_voice, n_voice;
    logic             r_out_valid, n_out_valid;
    mtsd_pkg::t_cmd   cmd;

    always_comb begin
        n_state     = r_state;
        n_voice     = r_voice;
        n_out_valid = r_out_valid && i_out_stall;
        cmd         = '0;
        unique case (r_state)
            mtsd_pkg::ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (i_sts.pos_last) begin
                    n_state = mtsd_pkg::ST_IDLE;
                end
            end
            mtsd_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_voice  = '0;
                    n_state  = mtsd_pkg::ST_TAP;
                end
            end
            mtsd_pkg::ST_TAP: begin
                cmd.tap = 1'b1;
                cmd.acc = (r_voice != '0);
                if (r_voice == VW'(VOICES - 1)) begin
                    n_state = mtsd_pkg::ST_WRITE;
                end else begin
                    n_voice = r_voice + VW'(1);
                end
            end
            mtsd_pkg::ST_WRITE: begin
                cmd.acc    = 1'b1;
                cmd.frm_wr = 1'b1;
                n_state    = mtsd_pkg::ST_DONE;
            end
            mtsd_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.push    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = mtsd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mtsd_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtsd_pkg::ST_CLEAR;
            r_voice     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_voice     <= n_voice;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != mtsd_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ===== sv/mtsd_dp.sv =====
// ---------------------------------------------------------------------------
// mtsd_dp
// datapath: spacing register, ring position, tap address stepping,
// per-channel accumulators, history ram and output register
// ---------------------------------------------------------------------------
module mtsd_dp #(
    parameter int VOICES  = 4,
    parameter int MAX_GAP = 512
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    input  logic [mtsd_pkg::SPC_W-1:0]            i_cfg_data,
    input  logic signed [mtsd_pkg::SAMPLE_W-1:0]  i_left_in,
    input  logic signed [mtsd_pkg::SAMPLE_W-1:0]  i_right_in,
    input  mtsd_pkg::t_cmd                        i_cmd,
    output mtsd_pkg::t_sts                        o_sts,
    output logic signed [mtsd_pkg::OUT_W-1:0]     o_left_out,
    output logic signed [mtsd_pkg::OUT_W-1:0]     o_right_out
);

    localparam int DEPTH = VOICES * MAX_GAP;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = ($clog2(DEPTH + 1) > mtsd_pkg::SPC_W) ?
                           $clog2(DEPTH + 1) + 1 : mtsd_pkg::SPC_W + 1;
    localparam int SW    = mtsd_pkg::SAMPLE_W;
    localparam int OW    = mtsd_pkg::OUT_W;

    logic [mtsd_pkg::SPC_W-1:0] r_spacing;
    logic [AW-1:0]              r_pos, n_pos;
    logic [AW-1:0]              r_addr;
    logic signed [SW-1:0]       r_left, r_right;
    logic signed [OW-1:0]       r_lacc, r_racc;
    logic signed [OW-1:0]       r_lout, r_rout;

    logic [CW-1:0]              spc_ext, spc_eff;
    logic [AW:0]                addr_ext, spc_a, addr_step;
    logic [AW-1:0]              tap_addr;
    logic                       wr_en;
    logic [2*SW-1:0]            wr_data, rd_data;
    logic signed [SW-1:0]       rd_left, rd_right;

    always_comb begin
        spc_ext = CW'(r_spacing);
        if (spc_ext == '0) begin
            spc_eff = CW'(1);
        end else if (spc_ext > CW'(MAX_GAP)) begin
            spc_eff = CW'(MAX_GAP);
        end else begin
            spc_eff = spc_ext;
        end
        spc_a    = (AW+1)'(spc_eff);
        addr_ext = {1'b0, r_addr};
        if (addr_ext < spc_a) begin
            addr_step = addr_ext + (AW+1)'(DEPTH) - spc_a;
        end else begin
            addr_step = addr_ext - spc_a;
        end
        tap_addr = addr_step[AW-1:0];
    end

    assign n_pos    = (r_pos == AW'(DEPTH - 1)) ? '0 : r_pos + AW'(1);
    assign wr_en    = i_cmd.clr_wr || i_cmd.frm_wr;
    assign wr_data  = i_cmd.frm_wr ? {r_left, r_right} : '0;
    assign rd_left  = $signed(rd_data[2*SW-1:SW]);
    assign rd_right = $signed(rd_data[SW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= mtsd_pkg::SPACING_RESET;
            r_pos     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_spacing <= i_cfg_data;
            end
            if (wr_en) begin
                r_pos <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_left  <= i_left_in;
            r_right <= i_right_in;
            r_lacc  <= OW'(i_left_in);
            r_racc  <= OW'(i_right_in);
            r_addr  <= r_pos;
        end else if (i_cmd.acc) begin
            r_lacc <= r_lacc + OW'(rd_left);
            r_racc <= r_racc + OW'(rd_right);
        end
        if (i_cmd.tap) begin
            r_addr <= tap_addr;
        end
        if (i_cmd.push) begin
            r_lout <= r_lacc;
            r_rout <= r_racc;
        end
    end

    mtsd_ram #(
        .WIDTH (2 * SW),
        .DEPTH (DEPTH)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_pos),
        .i_wr_data (wr_data),
        .i_rd_addr (tap_addr),
        .o_rd_data (rd_data)
    );

    assign o_sts.pos_last = (r_pos == AW'(DEPTH - 1));
    assign o_left_out     = r_lout;
    assign o_right_out    = r_rout;

endmodule

// ===== sv/mtsd_chk.sv =====
// ---------------------------------------------------------------------------
// mtsd_chk
// port-level checks on the delay mixer, bound to the top level
// ---------------------------------------------------------------------------
module mtsd_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic signed [mtsd_pkg::OUT_W-1:0]    o_left_out,
    input logic signed [mtsd_pkg::OUT_W-1:0]    o_right_out
);

    // history clear holds off frames straight after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> o_in_stall)
        else $error("frame input open during history clear");

    // one frame in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second frame taken while one is in flight");

    // a new result only appears after frame intake was closed
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result produced without a frame in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_left_out) && $stable(o_right_out)))
        else $error("stalled result changed");

endmodule

bind multi_tap_stereo_delay_mix_core mtsd_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_left_out  (o_left_out),
    .o_right_out (o_right_out)
);
